### rtl/mvt_pkg.sv
// Package for the matrix-vector transform: payload structs, widths and the
// pipeline stage record shared by the cells and the top level.
// No dependencies.
package mvt_pkg;

   // Element and arithmetic widths
   localparam int ELEM_W      = 32;
   localparam int PROD_W      = 2 * ELEM_W;
   localparam int ACC_W       = PROD_W + 2;
   localparam int NUM_COMP    = 4;
   localparam int CSR_DATA_W  = 64;
   localparam int NUM_REGS    = 8;
   localparam int CSR_INDEX_W = $clog2(NUM_REGS);

   // Saturation limits
   localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

   // Input transaction
   typedef struct packed {
      logic signed [ELEM_W-1:0] in_w;
      logic signed [ELEM_W-1:0] in_z;
      logic signed [ELEM_W-1:0] in_y;
      logic signed [ELEM_W-1:0] in_x;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic                     overflow;
      logic signed [ELEM_W-1:0] out_w;
      logic signed [ELEM_W-1:0] out_z;
      logic signed [ELEM_W-1:0] out_y;
      logic signed [ELEM_W-1:0] out_x;
   } rsp_type;

   // One column of the matrix, rows x..w at index 0..3
   typedef logic [NUM_COMP-1:0][ELEM_W-1:0] column_type;

   // Record handed from cell to cell: the input vector, the sum of the
   // products of earlier columns, and the products of the last column
   typedef struct packed {
      logic [NUM_COMP-1:0][ELEM_W-1:0] vec;
      logic [NUM_COMP-1:0][ACC_W-1:0]  acc;
      logic [NUM_COMP-1:0][PROD_W-1:0] prod;
   } stage_type;

endpackage

### rtl/mvt_cell.sv
// One cell of the transform chain: multiplies its vector component by one
// matrix column and folds the previous cell's products into the running sums.
// Depends on mvt_pkg.
module mvt_cell import mvt_pkg::*; #(
   parameter int COL = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  column_type col_elem,
   input  logic       up_valid,
   output logic       up_ready,
   input  stage_type  up_data,
   output logic       dn_valid,
   input  logic       dn_ready,
   output stage_type  dn_data
);

   localparam logic [1:0] COL_SEL = COL[1:0];

   logic      valid_ff;
   stage_type stage_ff;
   stage_type stage_in;

   // Accept when empty or when the downstream cell takes the current transaction
   assign up_ready = !valid_ff || dn_ready;

   // Add earlier products into the sums, form this column's products
   always_comb begin
      stage_in = up_data;
      for (int r = 0; r < NUM_COMP; r++) begin
         stage_in.acc[r] = up_data.acc[r] +
            {{(ACC_W-PROD_W){up_data.prod[r][PROD_W-1]}}, up_data.prod[r]};
         stage_in.prod[r] = $signed(col_elem[r]) * $signed(up_data.vec[COL_SEL]);
      end
   end

   // Hold or advance the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         stage_ff <= stage_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = stage_ff;

endmodule

### rtl/matrix_vector_transform.sv
// Pipeline: four column cells plus the round/saturate output register.
// Throughput: one transaction per cycle unless rsp_stall holds the chain;
// each cell holds one transaction and its four 32x32 multipliers.
// Reset: synchronous, clears all valid flags and loads the identity matrix.
// The user writes the matrix registers through the csr port only while idle; the block does not enforce this.
module matrix_vector_transform import mvt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data
);

   localparam logic [ELEM_W-1:0] ONE  = ELEM_W'(1) << FRAC_BITS;
   localparam logic [ACC_W-1:0]  HALF = ACC_W'(1) << (FRAC_BITS - 1);

   // Matrix held column-major: mat_ff[col][row]
   logic [NUM_COMP-1:0][NUM_COMP-1:0][ELEM_W-1:0] mat_ff;
   logic [NUM_COMP-1:0][NUM_COMP-1:0][ELEM_W-1:0] mat_in;

   logic [NUM_COMP:0] link_valid;
   logic [NUM_COMP:0] link_ready;
   stage_type         link_data [NUM_COMP+1];

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   logic [1:0] wr_col;
   logic [1:0] wr_row;

   // Decode the register write: two rows of one column per register
   assign wr_col = csr_index[CSR_INDEX_W-1:1];
   assign wr_row = {csr_index[0], 1'b0};

   always_comb begin
      mat_in = mat_ff;
      if (csr_write_en) begin
         mat_in[wr_col][wr_row]      = csr_wdata[ELEM_W-1:0];
         mat_in[wr_col][wr_row + 2'd1] = csr_wdata[CSR_DATA_W-1:ELEM_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_COMP; c++) begin
            for (int r = 0; r < NUM_COMP; r++) begin
               mat_ff[c][r] <= (c == r) ? ONE : '0;
            end
         end
      end else begin
         mat_ff <= mat_in;
      end
   end

   // Feed the chain: vector in, empty sums and products
   always_comb begin
      link_data[0]      = '0;
      link_data[0].vec[0] = req_data.in_x;
      link_data[0].vec[1] = req_data.in_y;
      link_data[0].vec[2] = req_data.in_z;
      link_data[0].vec[3] = req_data.in_w;
   end

   assign link_valid[0] = req_valid;
   assign req_stall     = !link_ready[0];

   // Chain of column cells
   for (genvar c = 0; c < NUM_COMP; c++) begin : g_cell
      mvt_cell #(
         .COL (c)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .col_elem (mat_ff[c]),
         .up_valid (link_valid[c]),
         .up_ready (link_ready[c]),
         .up_data  (link_data[c]),
         .dn_valid (link_valid[c+1]),
         .dn_ready (link_ready[c+1]),
         .dn_data  (link_data[c+1])
      );
   end

   // Final sum, round half up, saturate
   always_comb begin
      logic signed [ACC_W-1:0]  sum_s;
      logic signed [ACC_W-1:0]  rnd_s;
      logic [NUM_COMP-1:0][ELEM_W-1:0] res;
      logic [NUM_COMP-1:0] sat;
      res = '0;
      sat = '0;
      for (int r = 0; r < NUM_COMP; r++) begin
         sum_s = $signed(link_data[NUM_COMP].acc[r]) +
                 $signed({{(ACC_W-PROD_W){link_data[NUM_COMP].prod[r][PROD_W-1]}},
                          link_data[NUM_COMP].prod[r]}) +
                 $signed(HALF);
         rnd_s = sum_s >>> FRAC_BITS;
         sat[r] = !((&rnd_s[ACC_W-1:ELEM_W-1]) || !(|rnd_s[ACC_W-1:ELEM_W-1]));
         if (sat[r]) begin
            res[r] = rnd_s[ACC_W-1] ? SAT_MIN : SAT_MAX;
         end else begin
            res[r] = rnd_s[ELEM_W-1:0];
         end
      end
      rsp_data_in.out_x    = res[0];
      rsp_data_in.out_y    = res[1];
      rsp_data_in.out_z    = res[2];
      rsp_data_in.out_w    = res[3];
      rsp_data_in.overflow = |sat;
   end

   // Output register: drain when empty or taken
   assign link_ready[NUM_COMP] = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (link_ready[NUM_COMP]) begin
         rsp_valid_ff <= link_valid[NUM_COMP];
      end
      if (link_ready[NUM_COMP] && link_valid[NUM_COMP]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/mvt_checker.sv
// Port-level checks for matrix_vector_transform, attached by bind.
// Depends on mvt_pkg and the top level's port list.
module mvt_checker import mvt_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled result stays valid
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result transaction dropped");

   // A stalled result keeps its payload
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled result payload changed");

   // Input backpressure only arises from a stalled, waiting result
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");

   // Overflow flag only with a saturated component
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overflow |->
         rsp_data.out_x == SAT_MAX || rsp_data.out_x == SAT_MIN ||
         rsp_data.out_y == SAT_MAX || rsp_data.out_y == SAT_MIN ||
         rsp_data.out_z == SAT_MAX || rsp_data.out_z == SAT_MIN ||
         rsp_data.out_w == SAT_MAX || rsp_data.out_w == SAT_MIN)
      else $error("overflow set without a saturated component");

endmodule

bind matrix_vector_transform mvt_checker u_mvt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
